// ===== hw/rtl/kot_pkg.sv =====
package kot_pkg;

  // Default sizing of the table, handed to the top level parameters.
  localparam int DEF_MAX_ENTRIES  = 512;
  localparam int DEF_SLOT_COUNT   = 2048;
  localparam int DEF_KEY_WORDS    = 16;
  localparam int DEF_TEX_LANE_BIT = 64;

  // Widest key and slot index that any legal parameter set needs.
  localparam int KEY_BITS_MAX = 1024;
  localparam int SLOT_W_MAX   = 16;

  // Depth of the queue between the front and back ends.
  localparam int QUEUE_DEPTH = 2;

  localparam logic [31:0] FNV_BASIS      = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME      = 32'd16777619;
  localparam logic [31:0] SAT32          = 32'hFFFF_FFFF;
  localparam logic [31:0] TEX_MASK_RESET = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_SET_WINDOW = 2'd0,
    OP_QUAD       = 2'd1,
    OP_APPEND     = 2'd2,
    OP_CLEAR      = 2'd3
  } kot_op_t;

  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_NEW   = 2'd1,
    ST_DROP  = 2'd2
  } kot_status_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] key_word;
    logic        last_word;
    logic [31:0] window_id;
    logic [31:0] generation;
  } kot_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  entry_index;
    logic [31:0] quad_total;
    logic [31:0] append_total;
    logic [31:0] pass_total;
    logic [31:0] first_window;
    logic [31:0] drop_total;
    logic [9:0]  entry_count;
  } kot_res_t;

  // One command handed from the front end to the back end.
  typedef struct packed {
    kot_op_t                 op;
    logic [SLOT_W_MAX-1:0]   slot;
    logic [KEY_BITS_MAX-1:0] key;
    logic [31:0]             window_id;
    logic [31:0]             generation;
  } kot_job_t;

  // Saturating increment shared by the entry counters and the drop count.
  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == SAT32) ? v : v + 32'd1;
  endfunction

endpackage

// ===== hw/rtl/kot_front.sv =====
module kot_front import kot_pkg::*; #(
  parameter int SLOT_COUNT   = DEF_SLOT_COUNT,
  parameter int KEY_WORDS    = DEF_KEY_WORDS,
  parameter int TEX_LANE_BIT = DEF_TEX_LANE_BIT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  kot_req_t    in_req,
  input  logic        hold,
  output logic        busy,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output logic        push,
  output kot_job_t    push_job
);

  localparam int KEY_BITS = KEY_WORDS * 64;
  localparam int POS_W    = $clog2(KEY_WORDS + 1);
  localparam int WIDX_W   = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int BYTES    = KEY_WORDS * 8;
  localparam int BIDX_W   = $clog2(BYTES);
  localparam int SLOT_W   = $clog2(SLOT_COUNT);
  // Reciprocal of the slot count, scaled by 2^32 and rounded down.
  localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(SLOT_COUNT));

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_HASH = 4'b0010,
    F_MOD  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t                      state_r;
  logic [KEY_WORDS-1:0][63:0]   kbuf_r;
  logic [KEY_WORDS-1:0][63:0]   kcur;
  logic [POS_W-1:0]             pos_r;
  logic [KEY_BITS-1:0]          kjob_r;
  logic [KEY_BITS-1:0]          kmasked;
  logic [KEY_BITS+31:0]         lane_wide;
  kot_op_t                      op_r;
  logic [31:0]                  hash_r;
  logic [31:0]                  hash_nxt;
  logic [31:0]                  hash_x;
  logic [BIDX_W-1:0]            bidx_r;
  logic [31:0]                  rem_r;
  logic [31:0]                  quo_r;
  logic [63:0]                  prod;
  logic [31:0]                  qn;
  logic [1:0]                   kstep_r;
  logic [31:0]                  mask_r;
  logic                         accept;
  kot_op_t                      in_op;

  assign busy   = (state_r != F_IDLE) || hold;
  assign accept = start && !busy;
  assign in_op  = kot_op_t'(in_req.opcode);

  // Key buffer with the incoming word placed, then the texture lane masked.
  always_comb begin
    kcur = kbuf_r;
    if (pos_r < POS_W'(KEY_WORDS)) begin
      kcur[pos_r[WIDX_W-1:0]] = in_req.key_word;
    end
    lane_wide = {{KEY_BITS{1'b0}}, ~mask_r} << TEX_LANE_BIT;
    kmasked   = kcur & ~lane_wide[KEY_BITS-1:0];
  end

  // One FNV-1a byte step per cycle.
  assign hash_x   = hash_r ^ {24'd0, kjob_r[{bidx_r, 3'b000} +: 8]};
  assign hash_nxt = hash_x * FNV_PRIME;

  // Reduction of the hash by the slot count: the quotient estimate is at most
  // one short, so one corrective subtract finishes the remainder.
  assign prod = 64'(rem_r) * 64'(RECIP);
  assign qn   = quo_r * 32'(SLOT_COUNT);

  // Commands for the back end.
  always_comb begin
    push_job            = '0;
    push_job.op         = op_r;
    push_job.slot       = SLOT_W_MAX'(rem_r[SLOT_W-1:0]);
    push_job.key        = KEY_BITS_MAX'(kjob_r);
    push                = (state_r == F_PUSH) && !hold;
    if (state_r == F_IDLE) begin
      push_job.op         = in_op;
      push_job.window_id  = in_req.window_id;
      push_job.generation = in_req.generation;
      push = accept && ((in_op == OP_SET_WINDOW) || (in_op == OP_CLEAR));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      kbuf_r  <= '0;
      pos_r   <= '0;
      mask_r  <= TEX_MASK_RESET;
    end else begin
      if (cfg_wr_en) begin
        mask_r <= cfg_wr_data;
      end
      unique case (state_r)
        F_IDLE: begin
          if (accept) begin
            if (in_op == OP_CLEAR) begin
              kbuf_r <= '0;
              pos_r  <= '0;
            end else if (in_op != OP_SET_WINDOW) begin
              if (in_req.last_word) begin
                kjob_r  <= kmasked;
                op_r    <= in_op;
                kbuf_r  <= '0;
                pos_r   <= '0;
                hash_r  <= FNV_BASIS;
                bidx_r  <= '0;
                state_r <= F_HASH;
              end else begin
                kbuf_r <= kcur;
                if (pos_r < POS_W'(KEY_WORDS)) begin
                  pos_r <= pos_r + POS_W'(1);
                end
              end
            end
          end
        end
        F_HASH: begin
          hash_r <= hash_nxt;
          bidx_r <= bidx_r + BIDX_W'(1);
          if (bidx_r == BIDX_W'(BYTES - 1)) begin
            rem_r   <= hash_nxt;
            kstep_r <= 2'd0;
            state_r <= F_MOD;
          end
        end
        F_MOD: begin
          kstep_r <= kstep_r + 2'd1;
          if (kstep_r == 2'd0) begin
            quo_r <= prod[63:32];
          end else if (kstep_r == 2'd1) begin
            rem_r <= rem_r - qn;
          end else begin
            if (rem_r >= 32'(SLOT_COUNT)) begin
              rem_r <= rem_r - 32'(SLOT_COUNT);
            end
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!hold) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/kot_queue.sv =====
module kot_queue import kot_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  kot_job_t push_job,
  input  logic     pop,
  output logic     full,
  output logic     head_valid,
  output kot_job_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  kot_job_t          mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wp_r;
  logic [PTR_W-1:0]  rp_r;
  logic [CNT_W-1:0]  cnt_r;

  assign full       = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rp_r];

  // Storage needs no reset; only the pointers and the fill count do.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/kot_back.sv =====
module kot_back import kot_pkg::*; #(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int SLOT_COUNT  = DEF_SLOT_COUNT,
  parameter int KEY_WORDS   = DEF_KEY_WORDS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     head_valid,
  input  kot_job_t head,
  output logic     pop,
  output logic     clearing,
  output logic     out_strobe,
  output kot_res_t out_res
);

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int USED_W = $clog2(MAX_ENTRIES + 1);
  localparam int EIDX_W = $clog2(MAX_ENTRIES);
  localparam int WIDX_W = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int KA_W   = $clog2(MAX_ENTRIES * KEY_WORDS);

  typedef enum logic [8:0] {
    B_CLR      = 9'b000000001,
    B_IDLE     = 9'b000000010,
    B_SLOT_RD  = 9'b000000100,
    B_SLOT_CHK = 9'b000001000,
    B_CMP_RD   = 9'b000010000,
    B_CMP_CHK  = 9'b000100000,
    B_KEY_WR   = 9'b001000000,
    B_REC_RD   = 9'b010000000,
    B_REC_UPD  = 9'b100000000
  } bstate_t;

  typedef struct packed {
    logic [31:0] quad;
    logic [31:0] append;
    logic [31:0] pass;
    logic [31:0] gen_mark;
    logic        seen;
    logic [31:0] creator;
  } rec_t;

  logic [USED_W-1:0] slot_mem [SLOT_COUNT];
  logic [63:0]       key_mem  [MAX_ENTRIES * KEY_WORDS];
  rec_t              rec_mem  [MAX_ENTRIES];

  bstate_t            state_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [SLOT_W-1:0]  probe_r;
  logic [SLOT_W-1:0]  clr_r;
  logic [EIDX_W-1:0]  ent_r;
  logic [WIDX_W-1:0]  widx_r;
  logic [USED_W-1:0]  used_r;
  logic [31:0]        drops_r;
  logic [31:0]        curwin_r;
  logic [31:0]        curgen_r;
  logic               is_new_r;
  logic [USED_W-1:0]  slot_q;
  logic [63:0]        key_q;
  rec_t               rec_q;
  logic               out_strobe_r;
  kot_res_t           out_res_r;

  logic [KA_W-1:0]    key_addr;
  logic [63:0]        cmp_word;
  logic               s_empty;
  logic               s_live;
  logic               room;
  logic               probe_last;
  logic               chk_miss;
  logic               go_drop;
  logic               go_next;
  logic               create;
  logic               finish;
  logic               slot_we;
  logic [SLOT_W-1:0]  slot_wa;
  logic [USED_W-1:0]  slot_wd;
  logic [SLOT_W-1:0]  slot_next;
  rec_t               rec_base;
  rec_t               rec_upd;
  kot_op_t            op;

  assign op         = head.op;
  assign clearing   = (state_r == B_CLR);
  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

  assign key_addr = KA_W'(ent_r * KEY_WORDS) + KA_W'(widx_r);
  assign cmp_word = head.key[{widx_r, 6'b000000} +: 64];

  // Classification of the probed slot and of the key comparison.
  assign s_empty    = (slot_q == '0);
  assign s_live     = !s_empty && (slot_q <= used_r);
  assign room       = (used_r < USED_W'(MAX_ENTRIES));
  assign probe_last = (probe_r == SLOT_W'(SLOT_COUNT - 1));
  assign slot_next  = (slot_r == SLOT_W'(SLOT_COUNT - 1)) ? '0 : slot_r + SLOT_W'(1);
  assign chk_miss   = ((state_r == B_SLOT_CHK) && !s_empty && !s_live) ||
                      ((state_r == B_CMP_CHK) && (key_q != cmp_word));
  assign create     = (state_r == B_SLOT_CHK) && s_empty && room;
  assign go_drop    = ((state_r == B_SLOT_CHK) && s_empty && !room) ||
                      (chk_miss && probe_last);
  assign go_next    = chk_miss && !probe_last;
  assign finish     = go_drop || (state_r == B_REC_UPD);
  assign pop        = finish || ((state_r == B_IDLE) && head_valid &&
                      ((op == OP_SET_WINDOW) || (op == OP_CLEAR)));

  // Slot table write port: clearing sweep or a newly created entry.
  always_comb begin
    slot_we = 1'b0;
    slot_wa = slot_r;
    slot_wd = used_r + USED_W'(1);
    if (state_r == B_CLR) begin
      slot_we = 1'b1;
      slot_wa = clr_r;
      slot_wd = '0;
    end else if (create) begin
      slot_we = 1'b1;
    end
  end

  // Counter update of the matched or created entry.
  always_comb begin
    if (is_new_r) begin
      rec_base         = '0;
      rec_base.creator = curwin_r;
    end else begin
      rec_base = rec_q;
    end
    rec_upd = rec_base;
    if (op == OP_QUAD) begin
      rec_upd.quad = sat_inc(rec_base.quad);
      if (!rec_base.seen || (rec_base.gen_mark != curgen_r)) begin
        rec_upd.seen     = 1'b1;
        rec_upd.gen_mark = curgen_r;
        rec_upd.pass     = sat_inc(rec_base.pass);
      end
    end else begin
      rec_upd.append = sat_inc(rec_base.append);
    end
  end

  // Memories with registered reads.
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_q <= slot_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == B_KEY_WR) begin
      key_mem[key_addr] <= cmp_word;
    end
    key_q <= key_mem[key_addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == B_REC_UPD) begin
      rec_mem[ent_r] <= rec_upd;
    end
    rec_q <= rec_mem[ent_r];
  end

  // Result register, shown for one cycle.
  always_ff @(posedge clk) begin
    if (go_drop) begin
      out_res_r             <= '0;
      out_res_r.status      <= ST_DROP;
      out_res_r.drop_total  <= (op == OP_QUAD) ? sat_inc(drops_r) : drops_r;
      out_res_r.entry_count <= 10'(used_r);
    end else begin
      out_res_r.status       <= is_new_r ? ST_NEW : ST_FOUND;
      out_res_r.entry_index  <= 9'(ent_r);
      out_res_r.quad_total   <= rec_upd.quad;
      out_res_r.append_total <= rec_upd.append;
      out_res_r.pass_total   <= rec_upd.pass;
      out_res_r.first_window <= rec_upd.creator;
      out_res_r.drop_total   <= drops_r;
      out_res_r.entry_count  <= 10'(used_r);
    end
  end

  // Probe sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_CLR;
      clr_r        <= '0;
      used_r       <= '0;
      drops_r      <= '0;
      curwin_r     <= '0;
      curgen_r     <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= finish;
      if (go_drop && (op == OP_QUAD)) begin
        drops_r <= sat_inc(drops_r);
      end
      if (go_drop) begin
        state_r <= B_IDLE;
      end else if (go_next) begin
        probe_r <= probe_r + SLOT_W'(1);
        slot_r  <= slot_next;
        state_r <= B_SLOT_RD;
      end else begin
        unique case (state_r)
          B_CLR: begin
            clr_r <= clr_r + SLOT_W'(1);
            if (clr_r == SLOT_W'(SLOT_COUNT - 1)) begin
              state_r <= B_IDLE;
            end
          end
          B_IDLE: begin
            if (head_valid) begin
              unique case (op)
                OP_SET_WINDOW: begin
                  curwin_r <= head.window_id;
                  curgen_r <= head.generation;
                end
                OP_CLEAR: begin
                  used_r   <= '0;
                  drops_r  <= '0;
                  curwin_r <= '0;
                  curgen_r <= '0;
                  clr_r    <= '0;
                  state_r  <= B_CLR;
                end
                default: begin
                  slot_r  <= head.slot[SLOT_W-1:0];
                  probe_r <= '0;
                  state_r <= B_SLOT_RD;
                end
              endcase
            end
          end
          B_SLOT_RD: state_r <= B_SLOT_CHK;
          B_SLOT_CHK: begin
            widx_r <= '0;
            if (create) begin
              ent_r    <= EIDX_W'(used_r);
              used_r   <= used_r + USED_W'(1);
              is_new_r <= 1'b1;
              state_r  <= B_KEY_WR;
            end else begin
              ent_r    <= EIDX_W'(slot_q - USED_W'(1));
              is_new_r <= 1'b0;
              state_r  <= B_CMP_RD;
            end
          end
          B_CMP_RD: state_r <= B_CMP_CHK;
          B_CMP_CHK: begin
            if (widx_r == WIDX_W'(KEY_WORDS - 1)) begin
              state_r <= B_REC_RD;
            end else begin
              widx_r  <= widx_r + WIDX_W'(1);
              state_r <= B_CMP_RD;
            end
          end
          B_KEY_WR: begin
            if (widx_r == WIDX_W'(KEY_WORDS - 1)) begin
              state_r <= B_REC_UPD;
            end else begin
              widx_r <= widx_r + WIDX_W'(1);
            end
          end
          B_REC_RD: state_r <= B_REC_UPD;
          B_REC_UPD: state_r <= B_IDLE;
          default: state_r <= B_IDLE;
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/keyed_occurrence_counter_table.sv =====
// Keyed occurrence counter table.
// Requests arrive on in_req and are taken at a clock edge where start is high
// and busy is low. Key words are buffered; a request with last_word set runs a
// lookup and later gives one result on out_res, marked by out_strobe for one
// cycle. Set-window and clear requests give no result.
// A request that only buffers a key word leaves the front end free for the
// next one. A final key word is hashed byte by byte in the front end, the hash
// is reduced to a home slot by a quotient estimate, a product subtraction and a
// corrective subtract, and the command is handed over. The back end then reads
// and checks each slot probed, reads and compares each key word against a
// stored entry, writes the key of a new entry word by word, reads the counters
// of an existing entry and writes back the update; the result shows on the
// following cycle. A two-entry command queue lets the front end hash the next
// key while the back end probes. Each back-end check follows a registered read.
// After reset, and after each clear request, a clearing pass empties the slot
// table one slot at a time, with busy held high; the mask register can still be
// written. The receiver cannot stall: every result must be taken in the cycle
// in which out_strobe is high.
module keyed_occurrence_counter_table import kot_pkg::*; #(
  parameter int MAX_ENTRIES  = DEF_MAX_ENTRIES,
  parameter int SLOT_COUNT   = DEF_SLOT_COUNT,
  parameter int KEY_WORDS    = DEF_KEY_WORDS,
  parameter int TEX_LANE_BIT = DEF_TEX_LANE_BIT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  kot_req_t    in_req,
  output logic        out_strobe,
  output kot_res_t    out_res,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  logic     q_full;
  logic     q_valid;
  logic     q_push;
  logic     q_pop;
  logic     clearing;
  kot_job_t push_job;
  kot_job_t head;

  kot_front #(
    .SLOT_COUNT   (SLOT_COUNT),
    .KEY_WORDS    (KEY_WORDS),
    .TEX_LANE_BIT (TEX_LANE_BIT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req      (in_req),
    .hold        (q_full || clearing),
    .busy        (busy),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (q_push),
    .push_job    (push_job)
  );

  kot_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head       (head)
  );

  kot_back #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .SLOT_COUNT  (SLOT_COUNT),
    .KEY_WORDS   (KEY_WORDS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head       (head),
    .pop        (q_pop),
    .clearing   (clearing),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import kot_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  kot_req_t    in_req = '0;
  logic        out_strobe;
  kot_res_t    out_res;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;

  keyed_occurrence_counter_table i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_res    (out_res),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Requests waiting to be driven and lookup results still to come.
  kot_req_t req_queue[$];
  kot_res_t pending_tallies[$];
  int       pushed_cnt = 0;
  int       taken_cnt = 0;
  int       error_cnt = 0;
  int       n_created = 0;
  int       n_found = 0;
  int       n_dropped = 0;
  bit       quiet = 1'b0;
  int       gap = 0;
  logic [63:0] word_pool[8];

  // Shadow copy of the table state.
  logic [31:0]   keep_mask;
  int            slot_map[2048];
  logic [1023:0] stored_key[512];
  logic [31:0]   quad_cnt[512];
  logic [31:0]   append_cnt[512];
  logic [31:0]   pass_cnt[512];
  logic [31:0]   pass_gen[512];
  bit            gen_seen[512];
  logic [31:0]   born_window[512];
  int            used;
  logic [31:0]   drops;
  logic [31:0]   cur_win;
  logic [31:0]   cur_gen;
  logic [1023:0] kbuf;
  int            word_pos;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_cnt++;
  endtask

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic void wipe_state();
    foreach (slot_map[i]) slot_map[i] = 0;
    used = 0;
    drops = '0;
    cur_win = '0;
    cur_gen = '0;
    kbuf = '0;
    word_pos = 0;
  endfunction

  // Works out the result of one accepted request, if it causes one.
  task automatic tally_request(input kot_req_t r);
    logic [1023:0] k;
    logic [31:0]   h;
    int            slot;
    int            s;
    int            e;
    int            found;
    kot_res_t      res;
    case (r.opcode)
      OP_SET_WINDOW: begin
        cur_win = r.window_id;
        cur_gen = r.generation;
      end
      OP_CLEAR: wipe_state();
      default: begin
        if (word_pos < 16) begin
          kbuf[word_pos*64 +: 64] = r.key_word;
          word_pos++;
        end
        if (r.last_word) begin
          k = kbuf;
          for (int b = 0; b < 32; b++) if (!keep_mask[b]) k[64+b] = 1'b0;
          kbuf = '0;
          word_pos = 0;
          h = FNV_BASIS;
          for (int i = 0; i < 128; i++) begin
            h = h ^ {24'd0, k[8*i +: 8]};
            h = h * FNV_PRIME;
          end
          slot = int'(h[10:0]);
          found = -1;
          res = '0;
          res.status = ST_DROP;
          for (int p = 0; p < 2048; p++) begin
            s = slot_map[slot];
            if (s == 0) begin
              if (used < 512) begin
                e = used;
                stored_key[e] = k;
                quad_cnt[e] = '0;
                append_cnt[e] = '0;
                pass_cnt[e] = '0;
                pass_gen[e] = '0;
                gen_seen[e] = 1'b0;
                born_window[e] = cur_win;
                used = e + 1;
                slot_map[slot] = e + 1;
                found = e;
                res.status = ST_NEW;
              end
              break;
            end
            if (s - 1 < used && stored_key[s-1] == k) begin
              found = s - 1;
              res.status = ST_FOUND;
              break;
            end
            slot = (slot + 1) % 2048;
          end
          if (found < 0) begin
            if (r.opcode == OP_QUAD) drops = bump(drops);
            n_dropped++;
          end else begin
            e = found;
            if (r.opcode == OP_QUAD) begin
              quad_cnt[e] = bump(quad_cnt[e]);
              if (!gen_seen[e] || pass_gen[e] != cur_gen) begin
                gen_seen[e] = 1'b1;
                pass_gen[e] = cur_gen;
                pass_cnt[e] = bump(pass_cnt[e]);
              end
            end else begin
              append_cnt[e] = bump(append_cnt[e]);
            end
            if (res.status == ST_NEW) n_created++;
            else n_found++;
            res.entry_index = e[8:0];
            res.quad_total = quad_cnt[e];
            res.append_total = append_cnt[e];
            res.pass_total = pass_cnt[e];
            res.first_window = born_window[e];
          end
          res.drop_total = drops;
          res.entry_count = used[9:0];
          pending_tallies.push_back(res);
        end
      end
    endcase
  endtask

  // Driver: holds start high across back-to-back requests, with random gaps while quiet is clear.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap <= 0;
    end else if (!start || !busy) begin
      if (gap > 0) begin
        start <= 1'b0;
        gap <= gap - 1;
      end else if (req_queue.size() > 0) begin
        in_req <= req_queue.pop_front();
        start <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) gap <= $urandom_range(1, 14);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: tracks configuration and requests, and checks every result.
  always @(posedge clk) begin
    kot_res_t x;
    if (!rst_n) begin
      keep_mask = TEX_MASK_RESET;
      wipe_state();
    end else begin
      if (cfg_wr_en) keep_mask = cfg_wr_data;
      if (out_strobe) begin
        if (pending_tallies.size() == 0) begin
          report("result arrived with none expected");
        end else begin
          x = pending_tallies.pop_front();
          if (out_res.status !== x.status)
            report($sformatf("status %0d, expected %0d", out_res.status, x.status));
          if (out_res.entry_index !== x.entry_index)
            report($sformatf("entry_index %0d, expected %0d",
                             out_res.entry_index, x.entry_index));
          if (out_res.quad_total !== x.quad_total)
            report($sformatf("quad_total %0d, expected %0d",
                             out_res.quad_total, x.quad_total));
          if (out_res.append_total !== x.append_total)
            report($sformatf("append_total %0d, expected %0d",
                             out_res.append_total, x.append_total));
          if (out_res.pass_total !== x.pass_total)
            report($sformatf("pass_total %0d, expected %0d",
                             out_res.pass_total, x.pass_total));
          if (out_res.first_window !== x.first_window)
            report($sformatf("first_window %h, expected %h",
                             out_res.first_window, x.first_window));
          if (out_res.drop_total !== x.drop_total)
            report($sformatf("drop_total %0d, expected %0d",
                             out_res.drop_total, x.drop_total));
          if (out_res.entry_count !== x.entry_count)
            report($sformatf("entry_count %0d, expected %0d",
                             out_res.entry_count, x.entry_count));
        end
      end
      if (start && !busy) begin
        taken_cnt++;
        tally_request(in_req);
      end
    end
  end

  function automatic void push_req(input kot_op_t op, input logic [63:0] w, input bit last,
                                   input logic [31:0] win, input logic [31:0] gen);
    kot_req_t r;
    r.opcode = op;
    r.key_word = w;
    r.last_word = last;
    r.window_id = win;
    r.generation = gen;
    req_queue.push_back(r);
    pushed_cnt++;
  endfunction

  function automatic void push_window();
    push_req(OP_SET_WINDOW, {$urandom, $urandom}, 1'($urandom_range(0, 1)),
             $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 5),
             $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3));
  endfunction

  // Key words mostly come from a small pool so that keys repeat.
  function automatic logic [63:0] pick_word(input int idx);
    logic [63:0] w;
    w = $urandom_range(0, 4) == 0 ? {$urandom, $urandom} : word_pool[$urandom_range(0, 7)];
    if (idx == 1) w[31:0] = $urandom_range(0, 1) ? word_pool[$urandom_range(0, 3)][31:0]
                                                  : $urandom;
    return w;
  endfunction

  // One key, possibly with mixed opcodes and a window change in the middle.
  function automatic void push_record(input int len, input kot_op_t final_op, input bit mixed);
    kot_op_t op;
    for (int i = 0; i < len; i++) begin
      if (mixed && $urandom_range(0, 11) == 0) push_window();
      op = (i == len - 1 || !mixed) ? final_op : ($urandom_range(0, 1) ? OP_QUAD : OP_APPEND);
      push_req(op, pick_word(i), i == len - 1, $urandom, $urandom);
    end
  endfunction

  function automatic int pick_len();
    int c;
    c = $urandom_range(0, 19);
    if (c == 0) return 16;
    if (c == 1) return $urandom_range(17, 20);
    return $urandom_range(1, 4);
  endfunction

  function automatic void push_random(input int n);
    int c;
    repeat (n) begin
      c = $urandom_range(0, 99);
      if (c < 2) push_req(OP_CLEAR, {$urandom, $urandom}, 1'($urandom_range(0, 1)),
                          $urandom, $urandom);
      else if (c < 10) push_window();
      else if (c < 14) push_req(kot_op_t'($urandom_range(1, 2)), {$urandom, $urandom}, 1'b0,
                                $urandom, $urandom);
      else push_record(pick_len(), $urandom_range(0, 1) ? OP_QUAD : OP_APPEND,
                       $urandom_range(0, 2) == 0);
    end
  endfunction

  // Lets every queued request go in and every result come out, then covers
  // the latency of requests that give no result, such as a clear.
  task automatic drain();
    while (req_queue.size() > 0 || taken_cnt != pushed_cnt || pending_tallies.size() > 0)
      @(posedge clk);
    repeat (6000) @(posedge clk);
  endtask

  task automatic write_mask(input logic [31:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    #40ms;
    $display("[keyed_occurrence_counter_table] ERROR");
    $finish;
  end

  initial begin
    word_pool[0] = '0;
    word_pool[1] = '1;
    for (int i = 2; i < 8; i++) word_pool[i] = {$urandom, $urandom};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    write_mask(32'hFFFF_FFFF);

    // Directed: extremes, repeats, generations, short and long keys, clear.
    push_req(OP_SET_WINDOW, '0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(OP_QUAD, '0, 1'b1, '0, '0);
    push_req(OP_QUAD, '0, 1'b1, '0, '0);
    push_req(OP_APPEND, '0, 1'b1, '0, '0);
    push_req(OP_SET_WINDOW, '1, 1'b1, 32'd7, 32'd0);
    push_req(OP_QUAD, '0, 1'b1, '1, '1);
    drain();
    push_record(16, OP_QUAD, 1'b0);
    push_record(18, OP_APPEND, 1'b0);
    push_req(OP_APPEND, '1, 1'b0, '0, '0);
    push_req(OP_SET_WINDOW, '0, 1'b0, 32'd3, 32'd9);
    push_req(OP_QUAD, 64'h0123_4567_89AB_CDEF, 1'b1, '0, '0);
    push_req(OP_QUAD, '1, 1'b0, '0, '0);
    push_req(OP_QUAD, 64'h0123_4567_89AB_CDEF, 1'b1, '0, '0);
    push_req(OP_CLEAR, '1, 1'b1, '1, '1);
    push_req(OP_QUAD, '0, 1'b1, '0, '0);
    drain();

    write_mask(32'h0000_0000);
    push_random(90);
    drain();

    // Fill the table past its capacity with distinct one-word keys.
    write_mask($urandom);
    for (int i = 0; i < 530; i++)
      push_req($urandom_range(0, 1) ? OP_QUAD : OP_APPEND, {$urandom, 22'd0, i[9:0]},
               1'b1, '0, '0);
    push_req(OP_QUAD, '0, 1'b1, '0, '0);
    push_req(OP_CLEAR, '0, 1'b0, '0, '0);
    drain();

    write_mask(32'hFFFF_0000);
    push_random(85);
    while (req_queue.size() > 0) @(posedge clk);
    quiet = 1'b1;
    push_random(70);
    drain();

    $display("Covered %0d requests over four mask settings, including a full table.",
             taken_cnt);
    $display("Lookups: %0d created, %0d found, %0d dropped.", n_created, n_found, n_dropped);
    if (error_cnt == 0) $display("[keyed_occurrence_counter_table] OK");
    else $display("[keyed_occurrence_counter_table] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/kot_pkg.sv
hw/rtl/kot_front.sv
hw/rtl/kot_queue.sv
hw/rtl/kot_back.sv
hw/rtl/keyed_occurrence_counter_table.sv
verif/tb_top.sv
